FILE: rtl/rmar_pkg.sv
// ----------------------------------------------------------------------------
// rmar_pkg: shared types for the rational multiply/add/reduce block
// Holds the sequencer state type and the field widths of the result.
// ----------------------------------------------------------------------------
package rmar_pkg;

  localparam int unsigned NUM_OUT_W = 31;
  localparam int unsigned DEN_OUT_W = 30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_GCD_START,
    ST_GCD_RUN,
    ST_DIVN_START,
    ST_DIVN_RUN,
    ST_DIVD_START,
    ST_DIVD_RUN,
    ST_WHL_START,
    ST_WHL_RUN,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/rmar_if.sv
// ----------------------------------------------------------------------------
// rmar_in_if / rmar_out_if: valid/ready channels of the block
// Input carries two fractions and an operation; output the reduced result.
// ----------------------------------------------------------------------------
interface rmar_in_if #(parameter int OPERAND_BITS = 16);
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic signed [OPERAND_BITS-1:0] first_num;
  logic signed [OPERAND_BITS-1:0] first_den;
  logic signed [OPERAND_BITS-1:0] second_num;
  logic signed [OPERAND_BITS-1:0] second_den;
  modport source (output valid, operation, first_num, first_den, second_num,
                  second_den, input ready);
  modport sink (input valid, operation, first_num, first_den, second_num,
                second_den, output ready);
endinterface

interface rmar_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] result_num;
  logic [29:0] result_den;
  logic        is_whole;
  logic        bad_operand;
  modport source (output valid, result_num, result_den, is_whole, bad_operand,
                  input ready);
  modport sink (input valid, result_num, result_den, is_whole, bad_operand,
                output ready);
endinterface

FILE: rtl/rmar_div.sv
// ----------------------------------------------------------------------------
// rmar_div: restoring divider, one quotient bit per cycle
// Gives quotient and remainder of a W-bit dividend by a W-bit divisor.
// ----------------------------------------------------------------------------
module rmar_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt, r_r, r_nxt, d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // Load operands on start, else one shift-subtract step while busy
  always_comb begin
    trial    = {r_r, q_r[W-1]};
    diff     = trial - {1'b0, d_r};
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        r_nxt = diff[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    cnt_r <= cnt_nxt;
    if (start) d_r <= divisor;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;
endmodule

FILE: rtl/rational_mul_add_reduce.sv
// ----------------------------------------------------------------------------
// rational_mul_add_reduce: reduced product or sum of two fractions
// After acceptance: multiply states MUL1 and MUL2 (MUL3 too for add), a
// Euclid start state, Euclid steps on the divider, then three divisions
// (two reductions, one whole test), each of width W = 2*OPERAND_BITS+1 (33).
// A zero numerator skips Euclid and both reductions. Bad operands give their
// result the cycle after acceptance. One item at a time: ready again once the
// result is taken. Synchronous active-low reset idles it.
// ----------------------------------------------------------------------------
module rational_mul_add_reduce #(
  parameter int OPERAND_BITS = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  rmar_in_if.sink     in_ch,
  rmar_out_if.source  out_ch
);
  localparam int P = 2 * OPERAND_BITS;
  localparam int W = P + 1;

  rmar_pkg::state_t state_r, state_nxt;

  logic [OPERAND_BITS-1:0] a_r, b_r, c_r, d_r;
  logic                    add_r;
  logic [W-1:0]  num_r, den_r, x_r, y_r, rn_r, rd_r;
  logic [W-1:0]  div_a, div_b, quot, rem;
  logic [P-1:0]  prod;
  logic [OPERAND_BITS-1:0] ma, mb;
  logic          bad_r, whole_r, bad;
  logic          in_fire;
  logic          div_start, div_done;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign bad = in_ch.first_num[OPERAND_BITS-1] || in_ch.second_num[OPERAND_BITS-1]
             || in_ch.first_den[OPERAND_BITS-1] || in_ch.second_den[OPERAND_BITS-1]
             || (in_ch.first_den == '0) || (in_ch.second_den == '0);

  // Shared multiplier, one product per cycle
  always_comb begin
    ma = b_r; mb = d_r;
    case (state_r)
      rmar_pkg::ST_MUL2: begin ma = add_r ? a_r : a_r; mb = add_r ? d_r : c_r; end
      rmar_pkg::ST_MUL3: begin ma = b_r; mb = c_r; end
      default: ;
    endcase
    prod = P'(ma) * P'(mb);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rmar_pkg::ST_IDLE:       if (in_fire) state_nxt = bad ? rmar_pkg::ST_DONE
                                                              : rmar_pkg::ST_MUL1;
      rmar_pkg::ST_MUL1:       state_nxt = rmar_pkg::ST_MUL2;
      rmar_pkg::ST_MUL2:       state_nxt = add_r ? rmar_pkg::ST_MUL3
                                                 : rmar_pkg::ST_GCD_START;
      rmar_pkg::ST_MUL3:       state_nxt = rmar_pkg::ST_GCD_START;
      rmar_pkg::ST_GCD_START:  state_nxt = (num_r == '0) ? rmar_pkg::ST_WHL_START
                                                          : rmar_pkg::ST_GCD_RUN;
      rmar_pkg::ST_GCD_RUN:    if (div_done) state_nxt = (rem == '0)
                                 ? rmar_pkg::ST_DIVN_START : rmar_pkg::ST_GCD_RUN;
      rmar_pkg::ST_DIVN_START: state_nxt = rmar_pkg::ST_DIVN_RUN;
      rmar_pkg::ST_DIVN_RUN:   if (div_done) state_nxt = rmar_pkg::ST_DIVD_START;
      rmar_pkg::ST_DIVD_START: state_nxt = rmar_pkg::ST_DIVD_RUN;
      rmar_pkg::ST_DIVD_RUN:   if (div_done) state_nxt = rmar_pkg::ST_WHL_START;
      rmar_pkg::ST_WHL_START:  state_nxt = rmar_pkg::ST_WHL_RUN;
      rmar_pkg::ST_WHL_RUN:    if (div_done) state_nxt = rmar_pkg::ST_DONE;
      rmar_pkg::ST_DONE:       if (out_ch.ready) state_nxt = rmar_pkg::ST_IDLE;
      default:                 state_nxt = rmar_pkg::ST_IDLE;
    endcase
  end

  // Divider start and operand selection
  always_comb begin
    div_start = 1'b0;
    div_a = x_r;
    div_b = y_r;
    unique case (state_r)
      rmar_pkg::ST_GCD_START:  begin
                                 div_start = (num_r != '0); div_a = num_r; div_b = den_r;
                               end
      rmar_pkg::ST_GCD_RUN:    if (div_done && rem != '0) begin
                                 div_start = 1'b1; div_a = y_r; div_b = rem;
                               end
      rmar_pkg::ST_DIVN_START: begin div_start = 1'b1; div_a = num_r; div_b = x_r; end
      rmar_pkg::ST_DIVD_START: begin div_start = 1'b1; div_a = den_r; div_b = x_r; end
      rmar_pkg::ST_WHL_START:  begin div_start = 1'b1; div_a = rn_r; div_b = rd_r; end
      default: ;
    endcase
  end

  rmar_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot(quot), .rem(rem)
  );

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      rmar_pkg::ST_IDLE: if (in_fire) begin
        add_r <= in_ch.operation;
        a_r <= in_ch.first_num;  b_r <= in_ch.first_den;
        c_r <= in_ch.second_num; d_r <= in_ch.second_den;
        bad_r <= bad;
      end
      rmar_pkg::ST_MUL1: den_r <= W'(prod);
      rmar_pkg::ST_MUL2: num_r <= W'(prod);
      rmar_pkg::ST_MUL3: num_r <= num_r + W'(prod);
      rmar_pkg::ST_GCD_START: begin
        x_r <= num_r; y_r <= den_r; rn_r <= num_r; rd_r <= den_r;
      end
      rmar_pkg::ST_GCD_RUN: if (div_done) begin
        if (rem == '0) x_r <= y_r;
        else begin x_r <= y_r; y_r <= rem; end
      end
      rmar_pkg::ST_DIVN_RUN: if (div_done) rn_r <= quot;
      rmar_pkg::ST_DIVD_RUN: if (div_done) rd_r <= quot;
      rmar_pkg::ST_WHL_RUN:  if (div_done) whole_r <= (rem == '0);
      default: ;
    endcase
    if (!rst_n) state_r <= rmar_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Outputs
  always_comb begin
    in_ch.ready        = (state_r == rmar_pkg::ST_IDLE);
    out_ch.valid       = (state_r == rmar_pkg::ST_DONE);
    out_ch.bad_operand = bad_r;
    out_ch.result_num  = bad_r ? '0 : rmar_pkg::NUM_OUT_W'(rn_r);
    out_ch.result_den  = bad_r ? '0 : rmar_pkg::DEN_OUT_W'(rd_r);
    out_ch.is_whole    = bad_r ? 1'b0 : whole_r;
  end
endmodule
